>>> hw/rtl/rtsc_pkg.sv
// Shared types and constants for the resistive touch scan controller.
`timescale 1ns / 1ps
`default_nettype none

package rtsc_pkg;

    // Panel and scan geometry.
    localparam int SAMPLES       = 4;
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    // Field widths.
    localparam int RAW_W   = 16;
    localparam int ADC_W   = 10;
    localparam int PIX_W   = 12;
    localparam int PHASE_W = 4;
    localparam int MODE_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int CNT_W   = $clog2(SAMPLES + 1);
    localparam int PROD_W  = RAW_W + PIX_W;
    localparam int DCNT_W  = $clog2(PIX_W + 1);

    localparam logic [ADC_W-1:0]  FULL_CODE   = ADC_W'(1023);
    localparam logic [CNT_W-1:0]  SAMPLES_C   = CNT_W'(SAMPLES);
    localparam logic [PIX_W-1:0]  WIDTH_C     = PIX_W'(SCREEN_WIDTH);
    localparam logic [PIX_W-1:0]  HEIGHT_C    = PIX_W'(SCREEN_HEIGHT);
    localparam logic [DCNT_W-1:0] DIV_STEPS   = DCNT_W'(PIX_W);

    // Sequencer phases.
    localparam logic [PHASE_W-1:0] PH_PEN_DELAY = 4'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT      = 4'd1;
    localparam logic [PHASE_W-1:0] PH_SET_YF    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_MEAS_YF   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SET_YR    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_MEAS_YR   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SET_XF    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_MEAS_XF   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SET_XR    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_MEAS_XR   = 4'd9;

    localparam logic [MODE_W-1:0] MODE_Y_REV = 3'd2;

    typedef enum logic [1:0] {
        KIND_TIMER  = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_PEN    = 2'd2,
        KIND_POLL   = 2'd3
    } kind_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_X_LEFT      = 3'd0,
        CFG_X_RIGHT     = 3'd1,
        CFG_Y_TOP       = 3'd2,
        CFG_Y_BOTTOM    = 3'd3,
        CFG_SETTLE      = 3'd4,
        CFG_FIRST_SETTLE = 3'd5,
        CFG_RESCAN      = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic {
        AXIS_X = 1'b0,
        AXIS_Y = 1'b1
    } axis_t;

    typedef struct packed {
        logic  step;
        logic  mul;
        logic  div_step;
        logic  emit;
        axis_t axis;
    } dp_cmd_t;

    typedef struct packed {
        logic touch_next;
        logic clamp;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/rtsc_ctrl.sv
// Controller state machine: handshakes and sequencing of the datapath.
`timescale 1ns / 1ps
`default_nettype none

module rtsc_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    output rtsc_pkg::dp_cmd_t    cmd,
    input  rtsc_pkg::dp_status_t status
);
    import rtsc_pkg::*;

    ctrl_state_t state_reg, state_next;
    axis_t       axis_reg, axis_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    axis_next  = AXIS_X;
                    state_next = status.touch_next ? ST_MUL : ST_EMIT;
                end
            end
            ST_MUL: begin
                if (!status.clamp) begin
                    state_next = ST_DIV;
                end else if (axis_reg == AXIS_Y) begin
                    state_next = ST_EMIT;
                end else begin
                    axis_next = AXIS_Y;
                end
            end
            ST_DIV: begin
                if (status.div_last) begin
                    if (axis_reg == AXIS_Y) begin
                        state_next = ST_EMIT;
                    end else begin
                        axis_next  = AXIS_Y;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd            = '0;
        cmd.axis       = axis_reg;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.step = in_valid;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = slot_free;
                if (slot_free) begin
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rtsc_datapath.sv
// Datapath: configuration, scan state, pixel scaling unit and result register.
`timescale 1ns / 1ps
`default_nettype none

module rtsc_datapath (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  rtsc_pkg::cfg_idx_t                cfg_index,
    input  wire  [rtsc_pkg::RAW_W-1:0]        cfg_data,
    input  rtsc_pkg::kind_t                   kind,
    input  wire  [rtsc_pkg::ADC_W-1:0]        adc_sample,
    input  wire                               pen_level,
    input  rtsc_pkg::dp_cmd_t                 cmd,
    output rtsc_pkg::dp_status_t              status,
    output logic [rtsc_pkg::PHASE_W-1:0]      phase,
    output logic [rtsc_pkg::MODE_W-1:0]       panel_mode,
    output logic                              adc_channel,
    output logic                              adc_start,
    output logic                              timer_start,
    output logic [rtsc_pkg::RAW_W-1:0]        timer_load,
    output logic                              pen_irq_enable,
    output logic                              touched,
    output logic [rtsc_pkg::PIX_W-1:0]        x_pixel,
    output logic [rtsc_pkg::PIX_W-1:0]        y_pixel
);
    import rtsc_pkg::*;

    // Configuration registers.
    logic [RAW_W-1:0] x_left_reg, x_right_reg, y_top_reg, y_bottom_reg;
    logic [RAW_W-1:0] settle_reg, first_settle_reg, rescan_reg;

    // Scan state.
    logic [PHASE_W-1:0] seq_phase_reg, seq_phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RAW_W-1:0]   x_total_reg, x_total_next, y_total_reg, y_total_next;
    logic [RAW_W-1:0]   x_latched_reg, x_latched_next, y_latched_reg, y_latched_next;
    logic               touch_reg, touch_next, scan_done_reg, scan_done_next;
    logic               irq_reg, irq_next;

    // Per-item result fields held until scaling finishes.
    logic [PHASE_W-1:0] r_phase_reg;
    logic               r_adc_start_reg, r_timer_start_reg, r_irq_reg, r_touch_reg;
    logic [RAW_W-1:0]   r_timer_load_reg;
    logic [PIX_W-1:0]   r_x_pix_reg, r_y_pix_reg;

    // Output register.
    logic [PHASE_W-1:0] o_phase_reg;
    logic               o_adc_start_reg, o_timer_start_reg, o_irq_reg, o_touch_reg;
    logic [RAW_W-1:0]   o_timer_load_reg;
    logic [PIX_W-1:0]   o_x_pix_reg, o_y_pix_reg;

    // Step results.
    logic             st_adc_start, st_timer_start;
    logic [RAW_W-1:0] st_timer_load;
    logic [RAW_W-1:0] sample_term;
    logic [CNT_W-1:0] count_inc;

    // Scaling unit.
    logic [RAW_W-1:0]  sc_raw, sc_lo, sc_hi;
    logic [PIX_W-1:0]  sc_size;
    logic              sc_below, sc_above;
    logic [RAW_W-1:0]  sc_diff;
    logic [PROD_W-1:0] sc_prod;
    logic [PIX_W-1:0]  sc_clamped;
    logic [RAW_W-1:0]  rem_reg, rem_next;
    logic [PIX_W-1:0]  dq_reg, dq_next;
    logic [RAW_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [RAW_W:0]    trial;
    logic              trial_ge;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            x_left_reg       <= RAW_W'(800);
            x_right_reg      <= RAW_W'(7320);
            y_top_reg        <= RAW_W'(1000);
            y_bottom_reg     <= RAW_W'(7200);
            settle_reg       <= RAW_W'(100);
            first_settle_reg <= RAW_W'(1000);
            rescan_reg       <= RAW_W'(10000);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_X_LEFT:       x_left_reg       <= cfg_data;
                CFG_X_RIGHT:      x_right_reg      <= cfg_data;
                CFG_Y_TOP:        y_top_reg        <= cfg_data;
                CFG_Y_BOTTOM:     y_bottom_reg     <= cfg_data;
                CFG_SETTLE:       settle_reg       <= cfg_data;
                CFG_FIRST_SETTLE: first_settle_reg <= cfg_data;
                CFG_RESCAN:       rescan_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign count_inc = count_reg + 1'b1;

    // Sample term: the reversed Y and forward X phases take the complement.
    always_comb begin
        case (seq_phase_reg) inside
            PH_MEAS_YR, PH_MEAS_XF: sample_term = RAW_W'(FULL_CODE - adc_sample);
            default:                sample_term = RAW_W'(adc_sample);
        endcase
    end

    // One item of the scan sequencer.
    always_comb begin
        seq_phase_next = seq_phase_reg;
        count_next     = count_reg;
        x_total_next   = x_total_reg;
        y_total_next   = y_total_reg;
        x_latched_next = x_latched_reg;
        y_latched_next = y_latched_reg;
        touch_next     = touch_reg;
        scan_done_next = scan_done_reg;
        irq_next       = irq_reg;
        st_adc_start   = 1'b0;
        st_timer_start = 1'b0;
        st_timer_load  = '0;
        unique case (kind)
            KIND_TIMER: begin
                case (seq_phase_reg) inside
                    PH_SET_YF, PH_SET_YR, PH_SET_XF, PH_SET_XR: begin
                        seq_phase_next = seq_phase_reg + 1'b1;
                        st_adc_start   = 1'b1;
                    end
                    PH_PEN_DELAY: begin
                        seq_phase_next = PH_WAIT;
                        if (!pen_level) begin
                            touch_next     = 1'b0;
                            scan_done_next = 1'b0;
                            irq_next       = 1'b1;
                        end else begin
                            if (scan_done_reg) begin
                                x_latched_next = x_total_reg;
                                y_latched_next = y_total_reg;
                            end
                            touch_next     = scan_done_reg;
                            count_next     = '0;
                            x_total_next   = '0;
                            y_total_next   = '0;
                            seq_phase_next = PH_SET_YF;
                            st_timer_start = 1'b1;
                            st_timer_load  = scan_done_reg ? settle_reg : first_settle_reg;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_SAMPLE: begin
                case (seq_phase_reg) inside
                    PH_MEAS_YF, PH_MEAS_YR, PH_MEAS_XF, PH_MEAS_XR: begin
                        if (seq_phase_reg == PH_MEAS_YF || seq_phase_reg == PH_MEAS_YR) begin
                            y_total_next = y_total_reg + sample_term;
                        end else begin
                            x_total_next = x_total_reg + sample_term;
                        end
                        if (count_inc == SAMPLES_C) begin
                            count_next     = '0;
                            st_timer_start = 1'b1;
                            if (seq_phase_reg == PH_MEAS_XR) begin
                                seq_phase_next = PH_PEN_DELAY;
                                st_timer_load  = rescan_reg;
                                scan_done_next = 1'b1;
                            end else begin
                                seq_phase_next = seq_phase_reg + 1'b1;
                                st_timer_load  = settle_reg;
                            end
                        end else begin
                            count_next   = count_inc;
                            st_adc_start = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_PEN: begin
                if (irq_reg) begin
                    irq_next = 1'b0;
                    if (seq_phase_reg == PH_WAIT) begin
                        count_next     = '0;
                        x_total_next   = '0;
                        y_total_next   = '0;
                        seq_phase_next = PH_SET_YF;
                        st_timer_start = 1'b1;
                        st_timer_load  = touch_reg ? settle_reg : first_settle_reg;
                    end
                end
            end
            KIND_POLL: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seq_phase_reg <= PH_PEN_DELAY;
            count_reg     <= '0;
            x_total_reg   <= '0;
            y_total_reg   <= '0;
            x_latched_reg <= '0;
            y_latched_reg <= '0;
            touch_reg     <= 1'b0;
            scan_done_reg <= 1'b0;
            irq_reg       <= 1'b0;
        end else if (cmd.step) begin
            seq_phase_reg <= seq_phase_next;
            count_reg     <= count_next;
            x_total_reg   <= x_total_next;
            y_total_reg   <= y_total_next;
            x_latched_reg <= x_latched_next;
            y_latched_reg <= y_latched_next;
            touch_reg     <= touch_next;
            scan_done_reg <= scan_done_next;
            irq_reg       <= irq_next;
        end
    end

    // Scaling: clamp to the window, else (raw - lo) * size / (hi - lo).
    always_comb begin
        if (cmd.axis == AXIS_X) begin
            sc_raw  = x_latched_reg;
            sc_lo   = x_left_reg;
            sc_hi   = x_right_reg;
            sc_size = WIDTH_C;
        end else begin
            sc_raw  = y_latched_reg;
            sc_lo   = y_top_reg;
            sc_hi   = y_bottom_reg;
            sc_size = HEIGHT_C;
        end
    end

    assign sc_below   = sc_raw <= sc_lo;
    assign sc_above   = sc_raw >= sc_hi;
    assign sc_diff    = sc_raw - sc_lo;
    assign sc_prod    = PROD_W'(sc_diff) * PROD_W'(sc_size);
    assign sc_clamped = sc_below ? '0 : sc_size;

    // Restoring divide, one quotient bit a step. The quotient is below the
    // screen size, so the top bits of the product start below the divisor.
    assign trial    = {rem_reg, dq_reg[PIX_W-1]};
    assign trial_ge = trial >= {1'b0, dvs_reg};
    assign rem_next = trial_ge ? RAW_W'(trial - {1'b0, dvs_reg}) : trial[RAW_W-1:0];
    assign dq_next  = {dq_reg[PIX_W-2:0], trial_ge};

    always_ff @(posedge clk) begin
        if (cmd.mul) begin
            rem_reg  <= sc_prod[PROD_W-1:PIX_W];
            dq_reg   <= sc_prod[PIX_W-1:0];
            dvs_reg  <= sc_hi - sc_lo;
            dcnt_reg <= DIV_STEPS;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    assign status.touch_next = touch_next;
    assign status.clamp      = sc_below || sc_above;
    assign status.div_last   = dcnt_reg == DCNT_W'(1);

    // Pending result.
    always_ff @(posedge clk) begin
        if (cmd.step) begin
            r_phase_reg       <= seq_phase_next;
            r_adc_start_reg   <= st_adc_start;
            r_timer_start_reg <= st_timer_start;
            r_timer_load_reg  <= st_timer_load;
            r_irq_reg         <= irq_next;
            r_touch_reg       <= touch_next;
            r_x_pix_reg       <= '0;
            r_y_pix_reg       <= '0;
        end else if ((cmd.mul && status.clamp) || (cmd.div_step && status.div_last)) begin
            if (cmd.axis == AXIS_X) begin
                r_x_pix_reg <= cmd.mul ? sc_clamped : dq_next;
            end else begin
                r_y_pix_reg <= cmd.mul ? sc_clamped : dq_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk) begin
        if (cmd.emit) begin
            o_phase_reg       <= r_phase_reg;
            o_adc_start_reg   <= r_adc_start_reg;
            o_timer_start_reg <= r_timer_start_reg;
            o_timer_load_reg  <= r_timer_load_reg;
            o_irq_reg         <= r_irq_reg;
            o_touch_reg       <= r_touch_reg;
            o_x_pix_reg       <= r_x_pix_reg;
            o_y_pix_reg       <= r_y_pix_reg;
        end
    end

    assign phase          = o_phase_reg;
    assign panel_mode     = o_phase_reg[PHASE_W-1:1];
    assign adc_channel    = panel_mode <= MODE_Y_REV;
    assign adc_start      = o_adc_start_reg;
    assign timer_start    = o_timer_start_reg;
    assign timer_load     = o_timer_load_reg;
    assign pen_irq_enable = o_irq_reg;
    assign touched        = o_touch_reg;
    assign x_pixel        = o_x_pix_reg;
    assign y_pixel        = o_y_pix_reg;

endmodule

`default_nettype wire

>>> hw/rtl/resistive_touch_scan_controller_unit.sv
// Top level of the four-wire resistive touch panel scan controller.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake             | Beat contents
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_ready   | kind, adc_sample, pen_level
// out      | out_valid / out_ready | phase, panel_mode, adc_channel, adc_start,
//          |                       | timer_start, timer_load, pen_irq_enable,
//          |                       | touched, x_pixel, y_pixel
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each input beat yields exactly one output beat. The sequencer step is taken
// in the cycle the input beat is accepted. Without a latched touch the
// controller goes straight to its emit state; with a touch, each axis takes a
// multiply step and then the shared restoring divider (a clamped axis skips
// the divide). The emit state loads the output register once the output slot
// is free, and the controller then returns to idle. One item is in flight at
// a time; the output register lets a new input beat be accepted while the
// previous result still waits for out_ready.
// Reset is asynchronous and active low and loads the calibration and delay
// registers with their defaults; no clearing pass is needed. The configuration
// port is always ready.

module resistive_touch_scan_controller_unit (
    input  wire                           clk,
    input  wire                           rst_n,
    // Input beats.
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [1:0]                    kind,
    input  wire  [rtsc_pkg::ADC_W-1:0]    adc_sample,
    input  wire                           pen_level,
    // Result beats.
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [rtsc_pkg::PHASE_W-1:0]  phase,
    output logic [rtsc_pkg::MODE_W-1:0]   panel_mode,
    output logic                          adc_channel,
    output logic                          adc_start,
    output logic                          timer_start,
    output logic [rtsc_pkg::RAW_W-1:0]    timer_load,
    output logic                          pen_irq_enable,
    output logic                          touched,
    output logic [rtsc_pkg::PIX_W-1:0]    x_pixel,
    output logic [rtsc_pkg::PIX_W-1:0]    y_pixel,
    // Configuration writes.
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [rtsc_pkg::CIDX_W-1:0]   cfg_index,
    input  wire  [rtsc_pkg::RAW_W-1:0]    cfg_data
);
    import rtsc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Registers are to be written only while the block is idle; the block does
    // not enforce it. The port is always ready, so a write is taken at once.
    assign cfg_ready = 1'b1;

    rtsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    rtsc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_idx_t'(cfg_index)),
        .cfg_data       (cfg_data),
        .kind           (kind_t'(kind)),
        .adc_sample     (adc_sample),
        .pen_level      (pen_level),
        .cmd            (cmd),
        .status         (status),
        .phase          (phase),
        .panel_mode     (panel_mode),
        .adc_channel    (adc_channel),
        .adc_start      (adc_start),
        .timer_start    (timer_start),
        .timer_load     (timer_load),
        .pen_irq_enable (pen_irq_enable),
        .touched        (touched),
        .x_pixel        (x_pixel),
        .y_pixel        (y_pixel)
    );

endmodule

`default_nettype wire
